[rtl/idr_pkg.sv]
// Shared types, constants and register codes of the int8 x int16 dot-product requantizer.
package idr_pkg;

  localparam int WGT_W   = 8;
  localparam int ACT_W   = 16;
  localparam int ACC_W   = 32;
  localparam int SHIFT_W = 6;
  localparam int SAMT_W  = 5;
  localparam int RES_W   = 8;
  localparam int PROD_W  = 2 * ACC_W;
  localparam int MAC_W   = WGT_W + ACT_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Requantize tail depth, from the registered accumulator to the final lane result
  localparam int TAIL_N = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUTPUT_OFFSET = 2'd0,
    CFG_CLAMP_LOW     = 2'd1,
    CFG_CLAMP_HIGH    = 2'd2
  } cfg_idx_t;

  localparam logic signed [RES_W-1:0] OFFSET_RST    = 8'sd0;
  localparam logic signed [RES_W-1:0] CLAMP_LOW_RST = -8'sd128;
  localparam logic signed [RES_W-1:0] CLAMP_HIGH_RST = 8'sd127;

  localparam logic signed [ACC_W-1:0]  S32_MIN    = 32'sh8000_0000;
  localparam logic signed [ACC_W-1:0]  S32_MAX    = 32'sh7FFF_FFFF;
  localparam logic signed [PROD_W-1:0] NUDGE_POS  = 64'sh0000_0000_4000_0000;
  localparam logic signed [PROD_W-1:0] NUDGE_NEG  = 64'shFFFF_FFFF_C000_0001;
  localparam logic signed [PROD_W-1:0] TRUNC_BIAS = 64'sh0000_0000_7FFF_FFFF;

  typedef struct packed {
    logic signed [RES_W-1:0] output_offset;
    logic signed [RES_W-1:0] clamp_low;
    logic signed [RES_W-1:0] clamp_high;
  } cfg_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] multiplier;
    logic [SAMT_W-1:0]       lsh;
    logic [SAMT_W-1:0]       rsh;
  } rq_t;

  typedef struct packed {
    logic acc_en;   // accumulate this transaction
    logic first;    // load bias before the add
    logic fin_en;   // capture the final lane result
  } lane_ctl_t;

endpackage

[rtl/idr_if.sv]
// Handshake interfaces for the input, result and configuration channels.
interface idr_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [idr_pkg::WGT_W-1:0]        weight;
  logic signed [idr_pkg::ACT_W-1:0]        act_col0;
  logic signed [idr_pkg::ACT_W-1:0]        act_col1;
  logic signed [idr_pkg::ACC_W-1:0]        bias;
  logic signed [idr_pkg::ACC_W-1:0]        multiplier;
  logic signed [idr_pkg::SHIFT_W-1:0]      shift;
  logic                                    last_in_row;

  modport source (output valid, weight, act_col0, act_col1, bias, multiplier, shift,
                  last_in_row, input ready);
  modport sink (input valid, weight, act_col0, act_col1, bias, multiplier, shift,
                last_in_row, output ready);
endinterface

interface idr_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [idr_pkg::RES_W-1:0]   out_col0;
  logic signed [idr_pkg::RES_W-1:0]   out_col1;

  modport source (output valid, out_col0, out_col1, input ready);
  modport sink (input valid, out_col0, out_col1, output ready);
endinterface

interface idr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [idr_pkg::CFG_IDX_W-1:0]     index;
  logic [idr_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/int8_int16_dot_requantize.sv]
// Top level: two-column int8 x int16 dot product with per-channel requantization.
//
//  channel   dir  modport      payload
//  in_ch     in   sink         weight, act_col0, act_col1, bias, multiplier, shift, last_in_row
//  out_ch    out  source       out_col0, out_col1
//  cfg_ch    in   sink         index, data (output_offset, clamp_low, clamp_high)
//
// Items inside a row are taken one per cycle; each lane registers its MAC sum in its accumulator.
// After the last item of a row, in_ch.ready stays low while the requantize tail
// (shift, multiply, nudge, truncate, round, offset, clamp) runs. A stalled out_ch
// holds the finished lane results, and in_ch.ready waits until they move into the
// output register.
// Reset clears the accumulators, the row flag, the tail and the output valid, and
// loads the registers with offset 0 and clamp bounds -128 and 127.
module int8_int16_dot_requantize (
  input  logic       clk,
  input  logic       rst_n,
  idr_in_if.sink     in_ch,
  idr_out_if.source  out_ch,
  idr_cfg_if.sink    cfg_ch
);
  import idr_pkg::*;

  logic              in_fire, cfg_fire, take;
  logic              row_open_r, row_open_nxt;
  logic [TAIL_N-1:0] tv_r, tv_nxt;
  cfg_t              cfg_r, cfg_nxt;
  rq_t               rq_r, rq_nxt;
  lane_ctl_t         lane_ctl;
  logic [SHIFT_W-1:0] neg_sh;
  logic signed [RES_W-1:0] q0, q1;

  // Accept only while no row end is in the tail
  assign in_ch.ready  = (tv_r == '0);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;

  // Configuration writes; unknown indexes drop
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_fire) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_OUTPUT_OFFSET: cfg_nxt.output_offset = cfg_ch.data;
        CFG_CLAMP_LOW:     cfg_nxt.clamp_low     = cfg_ch.data;
        CFG_CLAMP_HIGH:    cfg_nxt.clamp_high    = cfg_ch.data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  // Row flag: the next transaction after a last one loads the bias
  assign row_open_nxt = in_fire ? !in_ch.last_in_row : row_open_r;

  // Tail valid chain; the final stage holds until the merge takes it
  always_comb begin
    tv_nxt    = {tv_r[TAIL_N-2:0], in_fire && in_ch.last_in_row};
    tv_nxt[TAIL_N-1] = tv_r[TAIL_N-2] || (tv_r[TAIL_N-1] && !take);
  end

  // Split the shift into a left amount and a right amount saturated at 31
  assign neg_sh = -in_ch.shift;
  always_comb begin
    rq_nxt = rq_r;
    if (in_fire && in_ch.last_in_row) begin
      rq_nxt.multiplier = in_ch.multiplier;
      rq_nxt.lsh = (!in_ch.shift[SHIFT_W-1]) ? in_ch.shift[SAMT_W-1:0] : '0;
      if (!in_ch.shift[SHIFT_W-1]) begin
        rq_nxt.rsh = '0;
      end else if (neg_sh[SHIFT_W-1]) begin
        rq_nxt.rsh = {SAMT_W{1'b1}};
      end else begin
        rq_nxt.rsh = neg_sh[SAMT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_open_r          <= 1'b0;
      tv_r                <= '0;
      cfg_r.output_offset <= OFFSET_RST;
      cfg_r.clamp_low     <= CLAMP_LOW_RST;
      cfg_r.clamp_high    <= CLAMP_HIGH_RST;
    end else begin
      row_open_r <= row_open_nxt;
      tv_r       <= tv_nxt;
      cfg_r      <= cfg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rq_r <= rq_nxt;
  end

  assign lane_ctl.acc_en = in_fire;
  assign lane_ctl.first  = !row_open_r;
  assign lane_ctl.fin_en = tv_r[TAIL_N-2];

  idr_lane u_lane0 (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (lane_ctl),
    .weight (in_ch.weight),
    .act    (in_ch.act_col0),
    .bias   (in_ch.bias),
    .rq     (rq_r),
    .cfg    (cfg_r),
    .q      (q0)
  );

  idr_lane u_lane1 (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (lane_ctl),
    .weight (in_ch.weight),
    .act    (in_ch.act_col1),
    .bias   (in_ch.bias),
    .rq     (rq_r),
    .cfg    (cfg_r),
    .q      (q1)
  );

  idr_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .fin_valid (tv_r[TAIL_N-1]),
    .col0      (q0),
    .col1      (q1),
    .take      (take),
    .out_ch    (out_ch)
  );

  // At most one row end travels the tail
  a_tail_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tv_r))
    else $error("more than one row end in the requantize tail");

  // A last transaction closes the row and starts the tail
  a_last_starts_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.last_in_row) |=> (tv_r[0] && !row_open_r))
    else $error("row end did not enter the tail");

  // A new result comes only from a finished tail
  a_out_from_tail: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(tv_r[TAIL_N-1]))
    else $error("result raised without a finished tail");

  // A held final stage keeps its lane results
  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (tv_r[TAIL_N-1] && !take) |=> (tv_r[TAIL_N-1] && $stable(q0) && $stable(q1)))
    else $error("held lane result changed");

endmodule

[rtl/idr_lane.sv]
// One column lane: 32-bit MAC accumulator followed by the requantize pipeline.
module idr_lane (
  input  logic                              clk,
  input  logic                              rst_n,
  input  idr_pkg::lane_ctl_t                ctl,
  input  logic signed [idr_pkg::WGT_W-1:0]  weight,
  input  logic signed [idr_pkg::ACT_W-1:0]  act,
  input  logic signed [idr_pkg::ACC_W-1:0]  bias,
  input  idr_pkg::rq_t                      rq,
  input  idr_pkg::cfg_t                     cfg,
  output logic signed [idr_pkg::RES_W-1:0]  q
);
  import idr_pkg::*;

  logic signed [MAC_W-1:0]  mac_p;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt, acc_base;
  logic signed [ACC_W-1:0]  sv_r, sv_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic                     sat2_r, sat3_r, sat2_nxt;
  logic signed [PROD_W-1:0] sum_r, sum_nxt, adj;
  logic signed [ACC_W-1:0]  hi_r, hi_nxt;
  logic [ACC_W-1:0]         mask, rem, thr;
  logic signed [ACC_W-1:0]  fl;
  logic signed [ACC_W-1:0]  rd_r, rd_nxt;
  logic signed [ACC_W:0]    ofs_sum, clamp_a, clamp_b;
  logic signed [RES_W-1:0]  q_r, q_nxt;

  // MAC: wrap at 32 bits
  assign mac_p    = MAC_W'(weight) * MAC_W'(act);
  assign acc_base = ctl.first ? bias : acc_r;
  assign acc_nxt  = acc_base + {{(ACC_W-MAC_W){mac_p[MAC_W-1]}}, mac_p};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctl.acc_en) begin
      acc_r <= acc_nxt;
    end
  end

  // Wrapping left shift, doubling high multiply, nudge, truncate toward zero
  assign sv_nxt   = acc_r <<< rq.lsh;
  assign prod_nxt = PROD_W'(sv_r) * PROD_W'(rq.multiplier);
  assign sum_nxt  = prod_r + (prod_r[PROD_W-1] ? NUDGE_NEG : NUDGE_POS);
  assign adj      = sum_r[PROD_W-1] ? (sum_r + TRUNC_BIAS) : sum_r;
  assign hi_nxt   = sat3_r ? S32_MAX : adj[PROD_W-2:ACC_W-1];
  assign sat2_nxt = (sv_r == S32_MIN) && (rq.multiplier == S32_MIN);

  // Rounding right shift, ties away from zero
  assign mask   = ~({ACC_W{1'b1}} << rq.rsh);
  assign rem    = hi_r & mask;
  assign thr    = (mask >> 1) + {{(ACC_W-1){1'b0}}, hi_r[ACC_W-1]};
  assign fl     = hi_r >>> rq.rsh;
  assign rd_nxt = fl + ((rem > thr) ? 32'sd1 : 32'sd0);

  // Offset at full width, low bound first, then high bound
  always_comb begin
    ofs_sum = {rd_r[ACC_W-1], rd_r} +
              {{(ACC_W+1-RES_W){cfg.output_offset[RES_W-1]}}, cfg.output_offset};
    clamp_a = {{(ACC_W+1-RES_W){cfg.clamp_low[RES_W-1]}}, cfg.clamp_low};
    clamp_b = {{(ACC_W+1-RES_W){cfg.clamp_high[RES_W-1]}}, cfg.clamp_high};
    if (ofs_sum < clamp_a) begin
      ofs_sum = clamp_a;
    end
    if (ofs_sum > clamp_b) begin
      ofs_sum = clamp_b;
    end
    q_nxt = ofs_sum[RES_W-1:0];
  end

  always_ff @(posedge clk) begin
    sv_r   <= sv_nxt;
    prod_r <= prod_nxt;
    sat2_r <= sat2_nxt;
    sum_r  <= sum_nxt;
    sat3_r <= sat2_r;
    hi_r   <= hi_nxt;
    rd_r   <= rd_nxt;
    if (ctl.fin_en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

[rtl/idr_merge.sv]
// Merge stage: joins both lane results into one output transaction register.
module idr_merge (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              fin_valid,
  input  logic signed [idr_pkg::RES_W-1:0]  col0,
  input  logic signed [idr_pkg::RES_W-1:0]  col1,
  output logic                              take,
  idr_out_if.source                         out_ch
);
  import idr_pkg::*;

  logic                    valid_r, valid_nxt;
  logic signed [RES_W-1:0] col0_r, col1_r;

  assign take      = fin_valid && (!valid_r || out_ch.ready);
  assign valid_nxt = take || (valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      col0_r <= col0;
      col1_r <= col1;
    end
  end

  assign out_ch.valid    = valid_r;
  assign out_ch.out_col0 = col0_r;
  assign out_ch.out_col1 = col1_r;

endmodule
